// ===== rtl/rrhc_pkg.sv =====
package rrhc_pkg;

    // Parser modes, one per phase of a packet.
    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_OTHER    = 3'd1,
        MODE_SWACK    = 3'd2,
        MODE_ACK      = 3'd3,
        MODE_READ_HDR = 3'd4,
        MODE_PAYLOAD  = 3'd5,
        MODE_DROP     = 3'd6
    } mode_t;

    // Result kinds as carried on m_tuser.
    typedef enum logic [2:0] {
        KIND_OTHER        = 3'd0,
        KIND_READ_PAYLOAD = 3'd1,
        KIND_READ_INFO    = 3'd2,
        KIND_ACK_INFO     = 3'd3,
        KIND_SWITCH_ACK   = 3'd4
    } kind_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOCAL_SWITCH_PORT = 2'd0;
    localparam logic [1:0] CFG_STORAGE_ADDRESS   = 2'd1;
    localparam logic [1:0] CFG_TRANSPORT_PORT    = 2'd2;

    // Transport opcodes recognized in the first header byte.
    localparam logic [7:0] OPC_READ_RESP_FIRST  = 8'd13;
    localparam logic [7:0] OPC_READ_RESP_MIDDLE = 8'd14;
    localparam logic [7:0] OPC_READ_RESP_LAST   = 8'd15;
    localparam logic [7:0] OPC_READ_RESP_ONLY   = 8'd16;
    localparam logic [7:0] OPC_ACK              = 8'd17;

    // Index of the final header byte for each header length.
    localparam logic [3:0] SWACK_LAST_POS     = 4'd4;
    localparam logic [3:0] FULL_HDR_LAST_POS  = 4'd15;
    localparam logic [3:0] SHORT_HDR_LAST_POS = 4'd11;

    // Sixteen header bytes, byte k is the k-th byte on the wire.
    typedef logic [15:0][7:0] hdr_bytes_t;

    // Control from the parser to the field decoder.
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  first;
    } ctl_t;

    // One result transaction.
    typedef struct packed {
        kind_t        kind;
        logic [7:0]   out_byte;
        logic         out_last;
        logic [63:0]  meta_word;
        logic [4:0]   flag_bits;
        logic [1:0]   pad_count;
        logic [3:0]   hdr_version;
        logic [15:0]  partition;
        logic [23:0]  queue_number;
        logic [23:0]  psn;
        logic [7:0]   syndrome;
        logic [23:0]  msn;
    } res_t;

endpackage

// ===== rtl/roce_rx_header_classifier.sv =====
// Byte-serial receive classifier for remote memory traffic. Each packet byte
// is one transaction on the s_ channel; the first byte's metadata is compared
// with the configured storage address and ports, and the packet is passed
// through as "other" bytes, parsed as a software ack (5-byte header), a
// transport ack (16 bytes) or a read response (12 or 16 bytes) whose payload
// bytes then follow with a last mark. Header results appear once the final
// header byte arrives; bytes after an ack header are dropped. The block takes
// one byte per cycle: each byte goes combinationally through the parser and
// field decoder into one output register; s_tready is high while it is empty
// or being taken. Configuration is written through the always-ready cfg_
// channel; the user must write it only while no packet is open (not enforced).
module roce_rx_header_classifier (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write channel.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // Input byte stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: data_byte[7:0], meta_id[23:8], meta_dest[39:24], meta_addr[71:40]
    input  logic [71:0]  s_tdata,
    input  logic         s_tlast,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: out_byte[7:0], meta_word[71:8], flag_bits[76:72],
    // pad_count[78:77], hdr_version[82:79], partition[98:83],
    // queue_number[122:99], psn[146:123], syndrome[154:147], msn[178:155],
    // zero fill[183:179]
    output logic [183:0] m_tdata,
    output logic         m_tlast,
    // m_tuser: kind[2:0]
    output logic [2:0]   m_tuser
);

    logic [15:0] lsp_reg;
    logic [31:0] storage_reg;
    logic [15:0] tport_reg;

    rrhc_pkg::mode_t      mode_reg, mode_next, idle_mode;
    logic [3:0]           pos_reg, pos_next, idx, last_pos;
    rrhc_pkg::hdr_bytes_t hdr_reg, hv;
    rrhc_pkg::ctl_t       ctl;
    rrhc_pkg::res_t       res, out_reg;
    logic                 out_valid_reg, out_valid_next;

    logic [7:0]  data_byte;
    logic [15:0] meta_id, meta_dest;
    logic [31:0] meta_addr;
    logic        s_fire, is_sw, is_tp, addr_ok, hdr_mode, hdr_done, read_opc;

    assign data_byte = s_tdata[7:0];
    assign meta_id   = s_tdata[23:8];
    assign meta_dest = s_tdata[39:24];
    assign meta_addr = s_tdata[71:40];

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsp_reg     <= '0;
            storage_reg <= '0;
            tport_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rrhc_pkg::CFG_LOCAL_SWITCH_PORT: lsp_reg     <= cfg_data[15:0];
                rrhc_pkg::CFG_STORAGE_ADDRESS:   storage_reg <= cfg_data;
                rrhc_pkg::CFG_TRANSPORT_PORT:    tport_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Header view with the current byte placed at its position.
    assign idx = (mode_reg == rrhc_pkg::MODE_IDLE) ? 4'd0 : pos_reg;
    always_comb begin
        hv      = hdr_reg;
        hv[idx] = data_byte;
    end

    // Classification of a packet on its first byte.
    assign addr_ok  = (meta_addr == storage_reg);
    assign is_sw    = (meta_dest == lsp_reg);
    assign is_tp    = (meta_dest == tport_reg);
    assign read_opc = data_byte inside {rrhc_pkg::OPC_READ_RESP_FIRST,
                                        rrhc_pkg::OPC_READ_RESP_MIDDLE,
                                        rrhc_pkg::OPC_READ_RESP_LAST,
                                        rrhc_pkg::OPC_READ_RESP_ONLY};
    always_comb begin
        if (!addr_ok || (!is_sw && !is_tp)) begin
            idle_mode = rrhc_pkg::MODE_OTHER;
        end else if (is_sw) begin
            idle_mode = rrhc_pkg::MODE_SWACK;
        end else if (data_byte == rrhc_pkg::OPC_ACK) begin
            idle_mode = rrhc_pkg::MODE_ACK;
        end else if (read_opc) begin
            idle_mode = rrhc_pkg::MODE_READ_HDR;
        end else begin
            idle_mode = rrhc_pkg::MODE_OTHER;
        end
    end

    // Header completion: the byte at the final header position has arrived.
    always_comb begin
        case (mode_reg)
            rrhc_pkg::MODE_SWACK: last_pos = rrhc_pkg::SWACK_LAST_POS;
            rrhc_pkg::MODE_READ_HDR:
                last_pos = (hdr_reg[0] == rrhc_pkg::OPC_READ_RESP_MIDDLE) ?
                           rrhc_pkg::SHORT_HDR_LAST_POS : rrhc_pkg::FULL_HDR_LAST_POS;
            default: last_pos = rrhc_pkg::FULL_HDR_LAST_POS;
        endcase
    end
    assign hdr_mode = (mode_reg == rrhc_pkg::MODE_SWACK) ||
                      (mode_reg == rrhc_pkg::MODE_ACK)   ||
                      (mode_reg == rrhc_pkg::MODE_READ_HDR);
    assign hdr_done = hdr_mode && (pos_reg == last_pos);

    // Next-state logic of the parser.
    always_comb begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        case (mode_reg)
            rrhc_pkg::MODE_IDLE: begin
                pos_next  = 4'd1;
                mode_next = s_tlast ? rrhc_pkg::MODE_IDLE : idle_mode;
            end
            rrhc_pkg::MODE_SWACK, rrhc_pkg::MODE_ACK, rrhc_pkg::MODE_READ_HDR: begin
                pos_next = pos_reg + 4'd1;
                if (s_tlast) begin
                    mode_next = rrhc_pkg::MODE_IDLE;
                end else if (hdr_done) begin
                    mode_next = (mode_reg == rrhc_pkg::MODE_READ_HDR) ?
                                rrhc_pkg::MODE_PAYLOAD : rrhc_pkg::MODE_DROP;
                end
            end
            rrhc_pkg::MODE_OTHER, rrhc_pkg::MODE_PAYLOAD, rrhc_pkg::MODE_DROP: begin
                if (s_tlast) begin
                    mode_next = rrhc_pkg::MODE_IDLE;
                end
            end
            default: begin
                mode_next = s_tlast ? rrhc_pkg::MODE_IDLE : rrhc_pkg::MODE_DROP;
            end
        endcase
    end

    // Output control: which kind of result this byte produces, if any.
    always_comb begin
        ctl = '0;
        case (mode_reg)
            rrhc_pkg::MODE_IDLE: begin
                ctl.valid = (idle_mode == rrhc_pkg::MODE_OTHER);
                ctl.kind  = rrhc_pkg::KIND_OTHER;
                ctl.first = 1'b1;
            end
            rrhc_pkg::MODE_OTHER: begin
                ctl.valid = 1'b1;
                ctl.kind  = rrhc_pkg::KIND_OTHER;
            end
            rrhc_pkg::MODE_PAYLOAD: begin
                ctl.valid = 1'b1;
                ctl.kind  = rrhc_pkg::KIND_READ_PAYLOAD;
            end
            rrhc_pkg::MODE_SWACK: begin
                ctl.valid = hdr_done;
                ctl.kind  = rrhc_pkg::KIND_SWITCH_ACK;
            end
            rrhc_pkg::MODE_ACK: begin
                ctl.valid = hdr_done;
                ctl.kind  = rrhc_pkg::KIND_ACK_INFO;
            end
            rrhc_pkg::MODE_READ_HDR: begin
                ctl.valid = hdr_done;
                ctl.kind  = rrhc_pkg::KIND_READ_INFO;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    rrhc_field_decode u_decode (
        .ctl       (ctl),
        .hv        (hv),
        .data_byte (data_byte),
        .byte_last (s_tlast),
        .meta_id   (meta_id),
        .meta_dest (meta_dest),
        .meta_addr (meta_addr),
        .res       (res)
    );

    // Output register occupancy.
    always_comb begin
        if (s_fire) begin
            out_valid_next = ctl.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= rrhc_pkg::MODE_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_fire) begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
            end
        end
    end

    // Header bytes and result payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hdr_reg <= hv;
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.out_last;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'd0, out_reg.msn, out_reg.syndrome, out_reg.psn,
                       out_reg.queue_number, out_reg.partition,
                       out_reg.hdr_version, out_reg.pad_count,
                       out_reg.flag_bits, out_reg.meta_word, out_reg.out_byte};

    // A byte in drop mode never loads a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && mode_reg == rrhc_pkg::MODE_DROP) |=> !out_valid_reg)
        else $error("dropped byte produced a result");

    // The last byte of a packet always returns the parser to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (mode_reg == rrhc_pkg::MODE_IDLE))
        else $error("parser not idle after last byte");

    // A completed read header followed by more bytes leads into payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && hdr_done && !s_tlast && mode_reg == rrhc_pkg::MODE_READ_HDR)
        |=> (mode_reg == rrhc_pkg::MODE_PAYLOAD && out_valid_reg &&
             out_reg.kind == rrhc_pkg::KIND_READ_INFO))
        else $error("read header did not lead into payload");

endmodule

// ===== rtl/rrhc_field_decode.sv =====
module rrhc_field_decode (
    input  rrhc_pkg::ctl_t       ctl,
    input  rrhc_pkg::hdr_bytes_t hv,
    input  logic [7:0]           data_byte,
    input  logic                 byte_last,
    input  logic [15:0]          meta_id,
    input  logic [15:0]          meta_dest,
    input  logic [31:0]          meta_addr,
    output rrhc_pkg::res_t       res
);

    logic [7:0] opc;
    logic       aeth;

    assign opc  = hv[0];
    assign aeth = (ctl.kind == rrhc_pkg::KIND_ACK_INFO) ||
                  (opc != rrhc_pkg::OPC_READ_RESP_MIDDLE);

    // Field extraction for the kind chosen by the parser.
    always_comb begin
        res      = '0;
        res.kind = ctl.kind;
        case (ctl.kind)
            rrhc_pkg::KIND_OTHER, rrhc_pkg::KIND_READ_PAYLOAD: begin
                res.out_byte = data_byte;
                res.out_last = byte_last;
                if (ctl.first) begin
                    res.meta_word    = {meta_id, meta_dest, meta_addr};
                    res.flag_bits[0] = 1'b1;
                end
            end
            rrhc_pkg::KIND_SWITCH_ACK: begin
                res.flag_bits    = {3'b000, hv[1][4], hv[0][2]};
                res.queue_number = {hv[2], hv[3], hv[4]};
                res.syndrome     = {3'b000, hv[0][1:0], hv[1][7:5]};
            end
            rrhc_pkg::KIND_READ_INFO, rrhc_pkg::KIND_ACK_INFO: begin
                res.flag_bits[0] = hv[1][7];
                res.flag_bits[1] = hv[1][6];
                res.flag_bits[2] = hv[8][7];
                res.pad_count    = hv[1][5:4];
                res.hdr_version  = hv[1][3:0];
                res.partition    = {hv[2], hv[3]};
                res.queue_number = {hv[5], hv[6], hv[7]};
                res.psn          = {hv[9], hv[10], hv[11]};
                if (aeth) begin
                    res.syndrome = hv[12];
                    res.msn      = {hv[13], hv[14], hv[15]};
                end
                // Read responses mark the first and last segment of a message.
                if (ctl.kind == rrhc_pkg::KIND_READ_INFO) begin
                    res.flag_bits[3] = opc inside {rrhc_pkg::OPC_READ_RESP_FIRST,
                                                   rrhc_pkg::OPC_READ_RESP_ONLY};
                    res.flag_bits[4] = opc inside {rrhc_pkg::OPC_READ_RESP_LAST,
                                                   rrhc_pkg::OPC_READ_RESP_ONLY};
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

endmodule
